@@ hdl/agc_ng_pkg.sv @@
`default_nettype none
package agc_ng_pkg;

   localparam int BLOCK_MAX      = 4096;
   localparam int POS_W          = $clog2(BLOCK_MAX);
   localparam int LEN_W          = 13;
   localparam int GAIN_FRAC_BITS = 12;
   localparam int TARGET_W       = 15;
   localparam int NUM_W          = TARGET_W + GAIN_FRAC_BITS;
   localparam int CNT_W          = $clog2(NUM_W);
   localparam int PEAK_W         = 17;
   localparam int SMP_W          = 16;
   localparam int GAIN_W         = 16;
   localparam int DIFF_W         = NUM_W + 1;
   localparam int GPROD_W        = DIFF_W + 17;
   localparam int GSUM_W         = GPROD_W - 16 + 1;
   localparam int APB_AW         = 5;
   localparam int APB_DW         = 32;

   localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1 << GAIN_FRAC_BITS);
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4 << GAIN_FRAC_BITS);
   localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(BLOCK_MAX);

   typedef enum logic [2:0] {
      REG_BLOCK_LEN    = 3'd0,
      REG_GATE_OPEN    = 3'd1,
      REG_GATE_CLOSE   = 3'd2,
      REG_HOLD_BLOCKS  = 3'd3,
      REG_TARGET_LEVEL = 3'd4,
      REG_ATTACK_RATE  = 3'd5,
      REG_RELEASE_RATE = 3'd6,
      REG_GAIN_CEILING = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic               func;
      logic signed [31:0] raw_word;
   } req_item_type;

   typedef struct packed {
      logic               out_valid;
      logic signed [15:0] pcm_sample;
      logic               block_last;
      logic               gate_is_open;
      logic [15:0]        applied_gain;
   } rsp_item_type;

   typedef struct packed {
      logic [12:0] block_len;
      logic [15:0] gate_open_level;
      logic [15:0] gate_close_level;
      logic [7:0]  hold_blocks;
      logic [14:0] target_level;
      logic [15:0] attack_rate;
      logic [15:0] release_rate;
      logic [15:0] gain_ceiling;
   } cfg_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MUL  = 8'b0000_0010,
      ST_OUT  = 8'b0000_0100,
      ST_CHK  = 8'b0000_1000,
      ST_DIV  = 8'b0001_0000,
      ST_GMUL = 8'b0010_0000,
      ST_GUPD = 8'b0100_0000,
      ST_FIN  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic commit;
      logic div_init;
      logic div_step;
      logic gmul;
      logic gupd;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic live_end;
      logic gain_go;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

@@ hdl/agc_ng_csr.sv @@
`default_nettype none
module agc_ng_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [agc_ng_pkg::APB_AW-1:0]     paddr,
   input  wire logic [agc_ng_pkg::APB_DW-1:0]     pwdata,
   output logic      [agc_ng_pkg::APB_DW-1:0]     prdata,
   output logic                                   pready,
   output agc_ng_pkg::cfg_type                    cfg
);

   agc_ng_pkg::cfg_type       cfg_ff, cfg_in;
   agc_ng_pkg::reg_index_type idx;
   logic                      wr;

   assign idx    = agc_ng_pkg::reg_index_type'(paddr[4:2]);
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            agc_ng_pkg::REG_BLOCK_LEN:    cfg_in.block_len        = pwdata[12:0];
            agc_ng_pkg::REG_GATE_OPEN:    cfg_in.gate_open_level  = pwdata[15:0];
            agc_ng_pkg::REG_GATE_CLOSE:   cfg_in.gate_close_level = pwdata[15:0];
            agc_ng_pkg::REG_HOLD_BLOCKS:  cfg_in.hold_blocks      = pwdata[7:0];
            agc_ng_pkg::REG_TARGET_LEVEL: cfg_in.target_level     = pwdata[14:0];
            agc_ng_pkg::REG_ATTACK_RATE:  cfg_in.attack_rate      = pwdata[15:0];
            agc_ng_pkg::REG_RELEASE_RATE: cfg_in.release_rate     = pwdata[15:0];
            agc_ng_pkg::REG_GAIN_CEILING: cfg_in.gain_ceiling     = pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         agc_ng_pkg::REG_BLOCK_LEN:    prdata = {19'd0, cfg_ff.block_len};
         agc_ng_pkg::REG_GATE_OPEN:    prdata = {16'd0, cfg_ff.gate_open_level};
         agc_ng_pkg::REG_GATE_CLOSE:   prdata = {16'd0, cfg_ff.gate_close_level};
         agc_ng_pkg::REG_HOLD_BLOCKS:  prdata = {24'd0, cfg_ff.hold_blocks};
         agc_ng_pkg::REG_TARGET_LEVEL: prdata = {17'd0, cfg_ff.target_level};
         agc_ng_pkg::REG_ATTACK_RATE:  prdata = {16'd0, cfg_ff.attack_rate};
         agc_ng_pkg::REG_RELEASE_RATE: prdata = {16'd0, cfg_ff.release_rate};
         agc_ng_pkg::REG_GAIN_CEILING: prdata = {16'd0, cfg_ff.gain_ceiling};
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_len        <= 13'd4096;
         cfg_ff.gate_open_level  <= 16'd300;
         cfg_ff.gate_close_level <= 16'd150;
         cfg_ff.hold_blocks      <= 8'd80;
         cfg_ff.target_level     <= 15'd8000;
         cfg_ff.attack_rate      <= 16'd655;
         cfg_ff.release_rate     <= 16'd66;
         cfg_ff.gain_ceiling     <= 16'd49152;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/agc_ng_ctrl.sv @@
`default_nettype none
module agc_ng_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire agc_ng_pkg::status_type status,
   output agc_ng_pkg::cmd_type         cmd
);

   agc_ng_pkg::state_type state_ff, state_in;

   assign req_ready = (state_ff == agc_ng_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         agc_ng_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = agc_ng_pkg::ST_MUL;
            end
         end
         agc_ng_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = agc_ng_pkg::ST_OUT;
         end
         agc_ng_pkg::ST_OUT: begin
            if (status.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = status.live_end ? agc_ng_pkg::ST_CHK : agc_ng_pkg::ST_IDLE;
            end
         end
         agc_ng_pkg::ST_CHK: begin
            if (status.gain_go) begin
               cmd.div_init = 1'b1;
               state_in     = agc_ng_pkg::ST_DIV;
            end else begin
               state_in = agc_ng_pkg::ST_FIN;
            end
         end
         agc_ng_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = agc_ng_pkg::ST_GMUL;
            end
         end
         agc_ng_pkg::ST_GMUL: begin
            cmd.gmul = 1'b1;
            state_in = agc_ng_pkg::ST_GUPD;
         end
         agc_ng_pkg::ST_GUPD: begin
            cmd.gupd = 1'b1;
            state_in = agc_ng_pkg::ST_FIN;
         end
         agc_ng_pkg::ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = agc_ng_pkg::ST_IDLE;
         end
         default: state_in = agc_ng_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= agc_ng_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/agc_ng_dp.sv @@
`default_nettype none
module agc_ng_dp (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire agc_ng_pkg::cfg_type      cfg,
   input  wire agc_ng_pkg::cmd_type      cmd,
   output agc_ng_pkg::status_type        status,
   input  wire agc_ng_pkg::req_item_type req_item,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output agc_ng_pkg::rsp_item_type      rsp_item
);

   localparam int PW = agc_ng_pkg::POS_W;
   localparam int LW = agc_ng_pkg::LEN_W;
   localparam int GW = agc_ng_pkg::GAIN_W;
   localparam int FB = agc_ng_pkg::GAIN_FRAC_BITS;

   logic [agc_ng_pkg::SMP_W-1:0] store [agc_ng_pkg::BLOCK_MAX];
   logic [agc_ng_pkg::SMP_W-1:0] rd_data_ff;

   agc_ng_pkg::req_item_type item_ff;
   logic [PW-1:0]  wp_ff, wp_in;
   logic [agc_ng_pkg::PEAK_W-1:0] peak_ff, peak_in, end_peak_ff, end_peak_in;
   logic           fill_ff, fill_in, prev_ff, prev_in;
   logic           gate_ff, gate_in, out_gate_ff, out_gate_in;
   logic [7:0]     hold_ff, hold_in;
   logic [GW-1:0]  gain_ff, gain_in, out_gain_ff, out_gain_in;
   logic           rsp_valid_ff, rsp_valid_in;
   agc_ng_pkg::rsp_item_type rsp_ff, rsp_in;

   logic signed [32:0] prod_ff;
   logic [agc_ng_pkg::NUM_W-1:0]  qn_ff;
   logic [agc_ng_pkg::PEAK_W-2:0] rem_ff;
   logic [agc_ng_pkg::CNT_W-1:0]  cnt_ff;
   logic signed [agc_ng_pkg::GPROD_W-1:0] gp_ff;

   logic [LW-1:0]  eff_len, wp_next;
   logic           blk_end, do_adv, fill_eff, st_we;
   logic signed [15:0] pk;
   logic [agc_ng_pkg::PEAK_W-1:0] mag, peak_eff;
   logic [agc_ng_pkg::SMP_W-1:0]  st_wd;
   logic [32:0]    p_abs;
   logic [20:0]    p_q;
   logic signed [21:0] p_a;
   logic signed [15:0] p_sat;
   logic [agc_ng_pkg::PEAK_W-1:0] rem_t;
   logic           rem_ge;
   logic signed [agc_ng_pkg::DIFF_W-1:0] diff;
   logic [15:0]    rate;
   logic [agc_ng_pkg::GPROD_W-1:0] gabs;
   logic signed [agc_ng_pkg::GSUM_W-1:0] gsum, gclamp;

   always_comb begin
      if (cfg.block_len == '0) begin
         eff_len = LW'(1);
      end else if (cfg.block_len > agc_ng_pkg::LEN_MAX) begin
         eff_len = agc_ng_pkg::LEN_MAX;
      end else begin
         eff_len = cfg.block_len;
      end
   end

   assign wp_next  = {1'b0, wp_ff} + LW'(1);
   assign blk_end  = (wp_next >= eff_len);
   assign do_adv   = ~item_ff.func | prev_ff | fill_ff;
   assign fill_eff = fill_ff | ~item_ff.func;
   assign pk       = item_ff.raw_word[23:8];
   assign mag      = pk[15] ? (agc_ng_pkg::PEAK_W)'(-{pk[15], pk})
                            : {1'b0, pk};
   assign peak_eff = (~item_ff.func && mag > peak_ff) ? mag : peak_ff;
   assign st_we    = cmd.commit & do_adv;
   assign st_wd    = item_ff.func ? '0 : item_ff.raw_word[29:14];

   always_ff @(posedge clock) begin
      if (st_we) begin
         store[wp_ff] <= st_wd;
      end
      rd_data_ff <= store[wp_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_item;
      end
      if (cmd.mul) begin
         prod_ff <= $signed(rd_data_ff) * $signed({1'b0, out_gain_ff});
      end
   end

   assign p_abs = prod_ff[32] ? 33'(-prod_ff) : prod_ff;
   assign p_q   = p_abs[32:FB];
   assign p_a   = prod_ff[32] ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q});

   always_comb begin
      if (p_a > 22'sd32767) begin
         p_sat = 16'sh7FFF;
      end else if (p_a < -22'sd32768) begin
         p_sat = 16'sh8000;
      end else begin
         p_sat = p_a[15:0];
      end
   end

   assign rem_t  = {rem_ff, qn_ff[agc_ng_pkg::NUM_W-1]};
   assign rem_ge = (rem_t >= end_peak_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         qn_ff  <= {cfg.target_level, FB'(0)};
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? (agc_ng_pkg::PEAK_W-1)'(rem_t - end_peak_ff)
                          : rem_t[agc_ng_pkg::PEAK_W-2:0];
         qn_ff  <= {qn_ff[agc_ng_pkg::NUM_W-2:0], rem_ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign diff = $signed({1'b0, qn_ff}) - $signed({(agc_ng_pkg::DIFF_W - GW)'(0), gain_ff});
   assign rate = diff[agc_ng_pkg::DIFF_W-1] ? cfg.attack_rate : cfg.release_rate;

   always_ff @(posedge clock) begin
      if (cmd.gmul) begin
         gp_ff <= diff * $signed({1'b0, rate});
      end
   end

   assign gabs = gp_ff[agc_ng_pkg::GPROD_W-1] ? (agc_ng_pkg::GPROD_W)'(-gp_ff) : gp_ff;
   assign gsum = gp_ff[agc_ng_pkg::GPROD_W-1]
               ? $signed({(agc_ng_pkg::GSUM_W - GW)'(0), gain_ff})
                 - $signed({1'b0, gabs[agc_ng_pkg::GPROD_W-1:16]})
               : $signed({(agc_ng_pkg::GSUM_W - GW)'(0), gain_ff})
                 + $signed({1'b0, gabs[agc_ng_pkg::GPROD_W-1:16]});

   always_comb begin
      gclamp = gsum;
      if (gclamp > $signed({(agc_ng_pkg::GSUM_W - GW)'(0), cfg.gain_ceiling})) begin
         gclamp = $signed({(agc_ng_pkg::GSUM_W - GW)'(0), cfg.gain_ceiling});
      end
      if (gclamp < $signed({(agc_ng_pkg::GSUM_W - GW)'(0), agc_ng_pkg::GAIN_ONE})) begin
         gclamp = $signed({(agc_ng_pkg::GSUM_W - GW)'(0), agc_ng_pkg::GAIN_ONE});
      end
   end

   always_comb begin
      wp_in        = wp_ff;
      peak_in      = peak_ff;
      end_peak_in  = end_peak_ff;
      fill_in      = fill_ff;
      prev_in      = prev_ff;
      gate_in      = gate_ff;
      hold_in      = hold_ff;
      gain_in      = gain_ff;
      out_gain_in  = out_gain_ff;
      out_gate_in  = out_gate_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (prev_ff) begin
            rsp_in.out_valid    = 1'b1;
            rsp_in.pcm_sample   = out_gate_ff ? p_sat : '0;
            rsp_in.block_last   = blk_end;
            rsp_in.gate_is_open = out_gate_ff;
            rsp_in.applied_gain = out_gain_ff;
         end
         if (do_adv) begin
            if (blk_end) begin
               wp_in   = '0;
               peak_in = '0;
               fill_in = 1'b0;
               if (fill_eff) begin
                  end_peak_in = peak_eff;
                  if (peak_eff > {1'b0, cfg.gate_open_level}) begin
                     gate_in = 1'b1;
                     hold_in = cfg.hold_blocks;
                  end else if (peak_eff < {1'b0, cfg.gate_close_level}) begin
                     if (hold_ff != '0) begin
                        hold_in = hold_ff - 1'b1;
                     end else begin
                        gate_in = 1'b0;
                     end
                  end
               end else begin
                  prev_in = 1'b0;
               end
            end else begin
               wp_in   = wp_next[PW-1:0];
               peak_in = peak_eff;
               fill_in = fill_eff;
            end
         end
      end
      if (cmd.gupd) begin
         gain_in = gclamp[GW-1:0];
      end
      if (cmd.fin) begin
         out_gain_in = gain_ff;
         out_gate_in = gate_ff;
         prev_in     = 1'b1;
      end
   end

   assign status.slot_free = ~rsp_valid_ff | rsp_ready;
   assign status.live_end  = do_adv & blk_end & fill_eff;
   assign status.gain_go   = gate_ff & (end_peak_ff != '0);
   assign status.div_done  = (cnt_ff == agc_ng_pkg::CNT_W'(agc_ng_pkg::NUM_W - 1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      end_peak_ff <= end_peak_in;
      if (reset) begin
         wp_ff        <= '0;
         peak_ff      <= '0;
         fill_ff      <= 1'b0;
         prev_ff      <= 1'b0;
         gate_ff      <= 1'b0;
         hold_ff      <= '0;
         gain_ff      <= agc_ng_pkg::GAIN_RESET;
         out_gain_ff  <= agc_ng_pkg::GAIN_RESET;
         out_gate_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         peak_ff      <= peak_in;
         fill_ff      <= fill_in;
         prev_ff      <= prev_in;
         gate_ff      <= gate_in;
         hold_ff      <= hold_in;
         gain_ff      <= gain_in;
         out_gain_ff  <= out_gain_in;
         out_gate_ff  <= out_gate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/block_agc_noise_gate_unit.sv @@
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  req_item (func, raw_word)
// rsp      out        rsp_valid/rsp_ready  rsp_item (one result per item)
// csr      in         APB write/read       eight configuration registers
//
// An item takes three steps: store read, output multiply, result and store write.
// An item that ends a block holding samples adds check and finish states, and when
// the gate is open with a nonzero peak also the one-bit-per-cycle gain divider.
// Reset clears all control state; the sample store is not cleared.
// A full result register holds the item in its result step until rsp_ready.
`default_nettype none
module block_agc_noise_gate_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire agc_ng_pkg::req_item_type      req_item,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output agc_ng_pkg::rsp_item_type           rsp_item,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [agc_ng_pkg::APB_AW-1:0] paddr,
   input  wire logic [agc_ng_pkg::APB_DW-1:0] pwdata,
   output logic      [agc_ng_pkg::APB_DW-1:0] prdata,
   output logic                               pready
);

   agc_ng_pkg::cfg_type    cfg;
   agc_ng_pkg::cmd_type    cmd;
   agc_ng_pkg::status_type status;

   agc_ng_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   agc_ng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   agc_ng_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import agc_ng_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_item_type rsp_item;
   logic psel = 0;
   logic penable = 0;
   logic pwrite = 0;
   logic [APB_AW-1:0] paddr = '0;
   logic [APB_DW-1:0] pwdata = '0;
   logic [APB_DW-1:0] prdata;
   logic pready;

   block_agc_noise_gate_unit dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Predictor state and its copy of the registers.
   logic [15:0] smp_mem [BLOCK_MAX];
   int c_len = 4096, c_open = 300, c_close = 150, c_hold = 80;
   int c_target = 8000, c_attack = 655, c_release = 66, c_ceiling = 49152;
   int wr_pos = 0, blk_peak = 0, hold_cnt = 0;
   longint gain_now = 16384, gain_out = 16384;
   bit gate_now = 0, gate_out = 0, pend_valid = 0, fill_busy = 0;

   req_item_type req_backlog[$];
   rsp_item_type pending_pcm[$];
   int idle_left = 0, stall_left = 0, long_hold = 0;
   int rsp_count = 0, mismatches = 0;
   bit quiet = 0;
   bit held_once = 0;
   longint cycles = 0;

   function automatic rsp_item_type next_pcm_result(req_item_type it);
      rsp_item_type r;
      int len;
      int pos;
      int pk;
      longint s, p, a, d, rate, prod, stp;
      r = '0;
      len = (c_len == 0) ? 1 : (c_len > BLOCK_MAX) ? BLOCK_MAX : c_len;
      pos = wr_pos;
      if (pend_valid) begin
         s = longint'($signed(smp_mem[pos]));
         a = 0;
         if (gate_out) begin
            p = s * gain_out;
            a = (p < 0) ? -((-p) >>> GAIN_FRAC_BITS) : (p >>> GAIN_FRAC_BITS);
            if (a > 32767) a = 32767;
            if (a < -32768) a = -32768;
         end
         r.out_valid = 1;
         r.pcm_sample = a[15:0];
         r.block_last = (wr_pos + 1 >= len);
         r.gate_is_open = gate_out;
         r.applied_gain = gain_out[15:0];
      end
      if (it.func == 1'b0 || pend_valid || fill_busy) begin
         if (it.func == 1'b0) begin
            pk = int'($signed(it.raw_word[23:8]));
            if (pk < 0) pk = -pk;
            smp_mem[pos] = it.raw_word[29:14];
            if (pk > blk_peak) blk_peak = pk;
            fill_busy = 1;
         end else begin
            smp_mem[pos] = '0;
         end
         if (wr_pos + 1 >= len) begin
            if (fill_busy) begin
               if (blk_peak > c_open) begin
                  gate_now = 1;
                  hold_cnt = c_hold;
               end else if (blk_peak < c_close) begin
                  if (hold_cnt > 0) hold_cnt--;
                  else gate_now = 0;
               end
               if (gate_now && blk_peak >= 1) begin
                  d = (longint'(c_target) << GAIN_FRAC_BITS) / blk_peak;
                  rate = (d < gain_now) ? c_attack : c_release;
                  prod = (d - gain_now) * rate;
                  stp = (prod < 0) ? -((-prod) / 65536) : prod / 65536;
                  gain_now = gain_now + stp;
                  if (gain_now > c_ceiling) gain_now = c_ceiling;
                  if (gain_now < 4096) gain_now = 4096;
               end
               gain_out = gain_now;
               gate_out = gate_now;
               pend_valid = 1;
            end else begin
               pend_valid = 0;
            end
            wr_pos = 0;
            blk_peak = 0;
            fill_busy = 0;
         end else begin
            wr_pos++;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      req_item_type nxt;
      logic nv;
      if (reset) begin
         req_valid <= 0;
      end else begin
         nv = req_valid;
         if (req_valid && req_ready) begin
            pending_pcm.push_back(next_pcm_result(req_item));
            nv = 0;
         end
         if (!nv) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (req_backlog.size() > 0) begin
               nxt = req_backlog.pop_front();
               req_item <= nxt;
               nv = 1;
               if (!quiet && $urandom_range(0, 7) == 0) idle_left = $urandom_range(1, 4);
            end
         end
         req_valid <= nv;
      end
   end

   always @(posedge clock) begin
      rsp_item_type exp_r;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (pending_pcm.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_item);
            end else begin
               exp_r = pending_pcm.pop_front();
               if (rsp_item !== exp_r) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at result %0d: expected %p, got %p",
                              rsp_count, exp_r, rsp_item);
               end
            end
         end
         if (!held_once && rsp_count == 300) begin
            held_once = 1;
            long_hold = 200;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_ready <= 0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 0;
         end else begin
            if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 4);
            rsp_ready <= (stall_left == 0);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic csr_write(reg_index_type idx, int val);
      @(posedge clock);
      psel <= 1;
      pwrite <= 1;
      penable <= 0;
      paddr <= APB_AW'(4 * int'(idx));
      pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      case (idx)
         REG_BLOCK_LEN:    c_len = val & 32'h1FFF;
         REG_GATE_OPEN:    c_open = val & 32'hFFFF;
         REG_GATE_CLOSE:   c_close = val & 32'hFFFF;
         REG_HOLD_BLOCKS:  c_hold = val & 32'hFF;
         REG_TARGET_LEVEL: c_target = val & 32'h7FFF;
         REG_ATTACK_RATE:  c_attack = val & 32'hFFFF;
         REG_RELEASE_RATE: c_release = val & 32'hFFFF;
         REG_GAIN_CEILING: c_ceiling = val & 32'hFFFF;
         default: ;
      endcase
   endtask

   task automatic settle();
      while (req_backlog.size() > 0 || req_valid || pending_pcm.size() > 0)
         @(negedge clock);
   endtask

   // Flush until no block is pending or filling, so a longer block never
   // reads store entries that were never written.
   task automatic drain_blocks();
      req_item_type it;
      settle();
      while (pend_valid || fill_busy) begin
         it = '0;
         it.func = 1;
         req_backlog.push_back(it);
         settle();
      end
      repeat (40) @(negedge clock);
   endtask

   task automatic apply_settings(int v[8]);
      csr_write(REG_BLOCK_LEN, v[0]);
      csr_write(REG_GATE_OPEN, v[1]);
      csr_write(REG_GATE_CLOSE, v[2]);
      csr_write(REG_HOLD_BLOCKS, v[3]);
      csr_write(REG_TARGET_LEVEL, v[4]);
      csr_write(REG_ATTACK_RATE, v[5]);
      csr_write(REG_RELEASE_RATE, v[6]);
      csr_write(REG_GAIN_CEILING, v[7]);
      @(negedge clock);
   endtask

   function automatic req_item_type random_word();
      req_item_type it;
      it.func = ($urandom_range(0, 19) == 0);
      it.raw_word = $signed($urandom) >>> $urandom_range(0, 26);
      return it;
   endfunction

   task automatic send(logic f, logic [31:0] w);
      req_item_type it;
      it.func = f;
      it.raw_word = w;
      req_backlog.push_back(it);
   endtask

   initial begin
      int v[8];
      int n;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(negedge clock);

      v = '{4, 300, 150, 2, 8000, 655, 66, 49152};
      apply_settings(v);
      send(1, 32'h1234_5678);
      send(0, 32'h7FFF_FFFF);
      send(0, 32'h8000_0000);
      send(0, 32'h0080_0000);
      send(0, 32'h0000_0000);
      send(0, 32'hFFFF_FFFF);
      send(0, 32'h3FFF_C000);
      send(1, 32'hFFFF_FFFF);
      send(0, 32'hC000_0000);
      send(0, 32'h0000_0100);
      send(0, 32'h007F_FF00);
      send(1, 32'h0);
      send(1, 32'h0);
      send(0, 32'h2000_0000);
      send(0, 32'hE000_0000);
      send(0, 32'h0000_00FF);
      send(1, 32'h0);
      send(1, 32'h0);
      send(1, 32'h0);
      send(1, 32'h0);
      send(1, 32'h0);
      drain_blocks();

      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: v = '{1, 0, 0, 0, 1, 0, 0, 0};
            1: v = '{0, 65535, 65535, 255, 32767, 65535, 65535, 61440};
            2: v = '{100, 100, 50, 3, 20000, 30000, 2000, 65535};
            3: v = '{64, 32768, 0, 255, 32767, 65535, 65535, 4096};
            default: begin
               v[0] = $urandom_range(2, 48);
               v[1] = $urandom_range(0, 3000);
               v[2] = $urandom_range(0, 3000);
               v[3] = $urandom_range(0, 6);
               v[4] = $urandom_range(1, 32767);
               v[5] = $urandom_range(0, 65535);
               v[6] = $urandom_range(0, 65535);
               v[7] = $urandom_range(0, 65535);
            end
         endcase
         apply_settings(v);
         quiet = (ph == 11);
         n = (ph < 2) ? 60 : 80;
         for (int k = 0; k < n; k++) req_backlog.push_back(random_word());
         drain_blocks();
      end

      repeat (50) @(negedge clock);
      if (mismatches == 0 && pending_pcm.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/agc_ng_pkg.sv
hdl/agc_ng_csr.sv
hdl/agc_ng_ctrl.sv
hdl/agc_ng_dp.sv
hdl/block_agc_noise_gate_unit.sv
test/testbench.sv
